// ===== rtl/core/rmth_pkg.sv =====
// Shared types and constants for the running median block.
package rmth_pkg;

  localparam int unsigned MEDIAN_WIDTH = 33;
  localparam int unsigned COUNT_WIDTH  = 11;

  // Operation codes issued by the controller to the datapath.
  typedef enum logic [2:0] {
    OP_NONE    = 3'd0,
    OP_READTOP = 3'd1,
    OP_PUSH    = 3'd2,
    OP_REPLACE = 3'd3
  } rmth_op_t;

  typedef struct packed {
    logic     start;
    rmth_op_t op;
    logic     sel_upper;
  } rmth_cmd_t;

  typedef struct packed {
    logic busy;
  } rmth_sts_t;

endpackage

// ===== rtl/core/rmth_if.sv =====
// Valid/ready channel interface carrying one item payload.
interface rmth_if #(
  parameter int unsigned W = 32
) (
  input logic clk
);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/rmth_ram.sv =====
// Generic single-port RAM with registered read.
module rmth_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ===== rtl/core/rmth_datapath.sv =====
// Heap datapath: two heap RAMs and a sift engine for push and root replacement.
module rmth_datapath #(
  parameter int unsigned SW    = 32,
  parameter int unsigned DEPTH = 512
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rmth_pkg::rmth_cmd_t  cmd,
  input  logic [SW-1:0]        val,
  input  logic [$clog2(DEPTH):0] size,
  output rmth_pkg::rmth_sts_t  sts,
  output logic [SW-1:0]        top
);
  import rmth_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned SZW = $clog2(DEPTH) + 1;

  typedef enum logic [8:0] {
    D_IDLE  = 9'b000000001,
    D_RDTOP = 9'b000000010,
    D_UPRD  = 9'b000000100,
    D_UPCMP = 9'b000001000,
    D_DNRL  = 9'b000010000,
    D_DNRR  = 9'b000100000,
    D_DNCMP = 9'b001000000,
    D_WR    = 9'b010000000,
    D_WAIT  = 9'b100000000
  } dstate_t;

  dstate_t          state_r, state_nxt;
  logic             upper_r, upper_nxt;
  logic [SW-1:0]    val_r, val_nxt;
  logic [SZW-1:0]   pos_r, pos_nxt;
  logic [SZW-1:0]   size_r, size_nxt;
  logic [SW-1:0]    lch_r, lch_nxt;
  logic [SW-1:0]    top_r, top_nxt;
  logic             lvalid_r, lvalid_nxt;

  logic             we_lo, we_up;
  logic [AW-1:0]    addr;
  logic [SW-1:0]    wdata;
  logic [SW-1:0]    rd_lo, rd_up, rd;

  logic [SZW-1:0]   parent, lidx, ridx;
  logic [SZW-1:0]   addr_full;

  rmth_ram #(.WIDTH(SW), .DEPTH(DEPTH)) u_lo (
    .clk(clk), .we(we_lo), .addr(addr), .wdata(wdata), .rdata(rd_lo));
  rmth_ram #(.WIDTH(SW), .DEPTH(DEPTH)) u_up (
    .clk(clk), .we(we_up), .addr(addr), .wdata(wdata), .rdata(rd_up));

  assign rd     = upper_r ? rd_up : rd_lo;
  assign parent = (pos_r - SZW'(1)) >> 1;
  assign lidx   = {pos_r[SZW-2:0], 1'b1};
  assign ridx   = lidx + SZW'(1);
  assign addr   = addr_full[AW-1:0];
  assign top    = top_r;
  assign sts.busy = (state_r != D_IDLE);

  // a outranks b in the selected heap's order.
  function automatic logic outr(input logic up, input logic [SW-1:0] a,
                                input logic [SW-1:0] b);
    outr = up ? ($signed(a) < $signed(b)) : ($signed(a) > $signed(b));
  endfunction

  always_comb begin
    state_nxt  = state_r;
    upper_nxt  = upper_r;
    val_nxt    = val_r;
    pos_nxt    = pos_r;
    size_nxt   = size_r;
    lch_nxt    = lch_r;
    top_nxt    = top_r;
    lvalid_nxt = lvalid_r;
    we_lo      = 1'b0;
    we_up      = 1'b0;
    addr_full  = pos_r;
    wdata      = val_r;
    unique case (state_r)
      D_IDLE: begin
        if (cmd.start) begin
          upper_nxt = cmd.sel_upper;
          val_nxt   = val;
          size_nxt  = size;
          case (cmd.op)
            OP_READTOP: begin
              addr_full = '0;
              state_nxt = D_RDTOP;
            end
            OP_PUSH: begin
              pos_nxt   = size;
              state_nxt = (size == '0) ? D_WR : D_UPRD;
            end
            OP_REPLACE: begin
              pos_nxt   = '0;
              state_nxt = D_DNRL;
            end
            default: state_nxt = D_IDLE;
          endcase
        end
      end
      D_RDTOP: begin
        // Keep the root addressed so the read data still holds it next cycle.
        addr_full = '0;
        state_nxt = D_WAIT;
      end
      D_WAIT: begin
        top_nxt   = rd;
        state_nxt = D_IDLE;
      end
      D_UPRD: begin
        addr_full = parent;
        state_nxt = D_UPCMP;
      end
      D_UPCMP: begin
        if (outr(upper_r, val_r, rd)) begin
          // Parent moves down into the hole.
          addr_full = pos_r;
          wdata     = rd;
          we_lo     = !upper_r;
          we_up     = upper_r;
          pos_nxt   = parent;
          state_nxt = (parent == '0) ? D_WR : D_UPRD;
        end else begin
          state_nxt = D_WR;
        end
      end
      D_DNRL: begin
        addr_full  = lidx;
        lvalid_nxt = (lidx < size_r);
        state_nxt  = D_DNRR;
      end
      D_DNRR: begin
        addr_full = ridx;
        lch_nxt   = rd;
        state_nxt = D_DNCMP;
      end
      D_DNCMP: begin
        // Pick the best child that outranks the carried value.
        if (lvalid_r && (ridx < size_r) && outr(upper_r, rd, lch_r)
            && outr(upper_r, rd, val_r)) begin
          addr_full = pos_r;
          wdata     = rd;
          we_lo     = !upper_r;
          we_up     = upper_r;
          pos_nxt   = ridx;
          state_nxt = D_DNRL;
        end else if (lvalid_r && outr(upper_r, lch_r, val_r)) begin
          addr_full = pos_r;
          wdata     = lch_r;
          we_lo     = !upper_r;
          we_up     = upper_r;
          pos_nxt   = lidx;
          state_nxt = D_DNRL;
        end else begin
          state_nxt = D_WR;
        end
      end
      D_WR: begin
        addr_full = pos_r;
        wdata     = val_r;
        we_lo     = !upper_r;
        we_up     = upper_r;
        state_nxt = D_IDLE;
      end
      default: state_nxt = D_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    upper_r  <= upper_nxt;
    val_r    <= val_nxt;
    pos_r    <= pos_nxt;
    size_r   <= size_nxt;
    lch_r    <= lch_nxt;
    top_r    <= top_nxt;
    lvalid_r <= lvalid_nxt;
  end

  ap_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |-> state_r == D_IDLE) else $error("start while busy");
  ap_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == D_WR |-> pos_r < SZW'(DEPTH)) else $error("write past depth");
  ap_wait: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == D_RDTOP |=> state_r == D_WAIT) else $error("top read lost");
endmodule

// ===== rtl/core/rmth_ctrl.sv =====
// Controller: sequences heap operations for one item and forms the result.
module rmth_ctrl #(
  parameter int unsigned SW       = 32,
  parameter int unsigned CAPACITY = 1024,
  parameter int unsigned DEPTH    = 512
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [SW-1:0]                     in_sample,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [rmth_pkg::MEDIAN_WIDTH-1:0] out_median,
  output logic [rmth_pkg::COUNT_WIDTH-1:0]  out_count,
  output logic                              out_rej,
  output rmth_pkg::rmth_cmd_t               cmd,
  output logic [SW-1:0]                     val,
  output logic [$clog2(DEPTH):0]            size,
  input  rmth_pkg::rmth_sts_t               sts,
  input  logic [SW-1:0]                     top
);
  import rmth_pkg::*;

  localparam int unsigned SZW = $clog2(DEPTH) + 1;

  typedef enum logic [10:0] {
    C_IDLE  = 11'b00000000001,
    C_RDLO  = 11'b00000000010,
    C_WLO   = 11'b00000000100,
    C_RDUP  = 11'b00000001000,
    C_WUP   = 11'b00000010000,
    C_DEC   = 11'b00000100000,
    C_OP1   = 11'b00001000000,
    C_W1    = 11'b00010000000,
    C_OP2   = 11'b00100000000,
    C_W2    = 11'b01000000000,
    C_TOPS  = 11'b10000000000
  } cstate_t;

  cstate_t        state_r, state_nxt;
  logic [SZW-1:0] lsz_r, lsz_nxt, usz_r, usz_nxt;
  logic [SW-1:0]  v_r, v_nxt, ltop_r, ltop_nxt, utop_r, utop_nxt;
  logic           rej_r, rej_nxt;
  logic           ovalid_r, ovalid_nxt;
  logic [MEDIAN_WIDTH-1:0] med_r, med_nxt;
  logic [COUNT_WIDTH-1:0]  cnt_r, cnt_nxt;
  // Plan: first op, second op (may be none), and what they carry.
  rmth_op_t       op1_r, op1_nxt, op2_r, op2_nxt;
  logic           h1_r, h1_nxt, h2_r, h2_nxt;
  logic [SW-1:0]  a1_r, a1_nxt, a2_r, a2_nxt;
  logic           tops_r, tops_nxt;

  logic [SZW:0]   total;
  logic signed [MEDIAN_WIDTH-1:0] lx, ux;

  assign total    = {1'b0, lsz_r} + {1'b0, usz_r};
  assign in_ready = (state_r == C_IDLE) && !ovalid_r;
  assign out_valid  = ovalid_r;
  assign out_median = med_r;
  assign out_count  = cnt_r;
  assign out_rej    = rej_r;
  assign lx = MEDIAN_WIDTH'($signed(ltop_r));
  assign ux = MEDIAN_WIDTH'($signed(utop_r));

  always_comb begin
    state_nxt  = state_r;
    lsz_nxt    = lsz_r;
    usz_nxt    = usz_r;
    v_nxt      = v_r;
    ltop_nxt   = ltop_r;
    utop_nxt   = utop_r;
    rej_nxt    = rej_r;
    ovalid_nxt = ovalid_r;
    med_nxt    = med_r;
    cnt_nxt    = cnt_r;
    op1_nxt    = op1_r;
    op2_nxt    = op2_r;
    h1_nxt     = h1_r;
    h2_nxt     = h2_r;
    a1_nxt     = a1_r;
    a2_nxt     = a2_r;
    tops_nxt   = tops_r;
    cmd        = '{start: 1'b0, op: OP_NONE, sel_upper: 1'b0};
    val        = a1_r;
    size       = lsz_r;
    if (ovalid_r && out_ready) begin
      ovalid_nxt = 1'b0;
    end
    unique case (state_r)
      C_IDLE: begin
        if (in_valid && in_ready) begin
          v_nxt     = in_sample;
          rej_nxt   = (total >= (SZW+1)'(CAPACITY));
          tops_nxt  = 1'b0;
          state_nxt = (total >= (SZW+1)'(CAPACITY)) ? C_TOPS : C_RDLO;
        end
      end
      C_RDLO: begin
        cmd = '{start: 1'b1, op: OP_READTOP, sel_upper: 1'b0};
        state_nxt = C_WLO;
      end
      C_WLO: begin
        if (!sts.busy) begin
          ltop_nxt  = top;
          state_nxt = C_RDUP;
        end
      end
      C_RDUP: begin
        cmd = '{start: 1'b1, op: OP_READTOP, sel_upper: 1'b1};
        state_nxt = C_WUP;
      end
      C_WUP: begin
        if (!sts.busy) begin
          utop_nxt  = top;
          state_nxt = tops_r ? C_TOPS : C_DEC;
        end
      end
      C_DEC: begin
        op2_nxt = OP_NONE;
        if (lsz_r == '0 || $signed(ltop_r) >= $signed(v_r)) begin
          if (lsz_r > usz_r) begin
            op1_nxt = OP_REPLACE; h1_nxt = 1'b0; a1_nxt = v_r;
            op2_nxt = OP_PUSH;    h2_nxt = 1'b1; a2_nxt = ltop_r;
          end else begin
            op1_nxt = OP_PUSH; h1_nxt = 1'b0; a1_nxt = v_r;
          end
        end else if (usz_r > lsz_r) begin
          if ($signed(v_r) <= $signed(utop_r)) begin
            op1_nxt = OP_PUSH; h1_nxt = 1'b0; a1_nxt = v_r;
          end else begin
            op1_nxt = OP_REPLACE; h1_nxt = 1'b1; a1_nxt = v_r;
            op2_nxt = OP_PUSH;    h2_nxt = 1'b0; a2_nxt = utop_r;
          end
        end else begin
          op1_nxt = OP_PUSH; h1_nxt = 1'b1; a1_nxt = v_r;
        end
        state_nxt = C_OP1;
      end
      C_OP1: begin
        cmd  = '{start: 1'b1, op: op1_r, sel_upper: h1_r};
        val  = a1_r;
        size = h1_r ? usz_r : lsz_r;
        if (op1_r == OP_PUSH) begin
          if (h1_r) usz_nxt = usz_r + SZW'(1);
          else      lsz_nxt = lsz_r + SZW'(1);
        end
        state_nxt = C_W1;
      end
      C_W1: begin
        if (!sts.busy) begin
          state_nxt = (op2_r == OP_NONE) ? C_RDLO : C_OP2;
          tops_nxt  = (op2_r == OP_NONE);
        end
      end
      C_OP2: begin
        cmd  = '{start: 1'b1, op: op2_r, sel_upper: h2_r};
        val  = a2_r;
        size = h2_r ? usz_r : lsz_r;
        if (h2_r) usz_nxt = usz_r + SZW'(1);
        else      lsz_nxt = lsz_r + SZW'(1);
        state_nxt = C_W2;
      end
      C_W2: begin
        if (!sts.busy) begin
          tops_nxt  = 1'b1;
          state_nxt = C_RDLO;
        end
      end
      C_TOPS: begin
        if (lsz_r > usz_r)      med_nxt = lx <<< 1;
        else if (usz_r > lsz_r) med_nxt = ux <<< 1;
        else if (lsz_r == '0)   med_nxt = '0;
        else                    med_nxt = lx + ux;
        cnt_nxt    = COUNT_WIDTH'(total);
        ovalid_nxt = 1'b1;
        state_nxt  = C_IDLE;
      end
      default: state_nxt = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= C_IDLE;
      lsz_r    <= '0;
      usz_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      lsz_r    <= lsz_nxt;
      usz_r    <= usz_nxt;
      ovalid_r <= ovalid_nxt;
    end
    v_r    <= v_nxt;
    ltop_r <= ltop_nxt;
    utop_r <= utop_nxt;
    rej_r  <= rej_nxt;
    med_r  <= med_nxt;
    cnt_r  <= cnt_nxt;
    op1_r  <= op1_nxt;
    op2_r  <= op2_nxt;
    h1_r   <= h1_nxt;
    h2_r   <= h2_nxt;
    a1_r   <= a1_nxt;
    a2_r   <= a2_nxt;
    tops_r <= tops_nxt;
  end

  ap_balance: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == C_IDLE |-> (lsz_r <= usz_r + SZW'(1)) && (usz_r <= lsz_r + SZW'(1)))
    else $error("heaps out of balance");
  ap_cap: assert property (@(posedge clk) disable iff (!rst_n)
    total <= (SZW+1)'(CAPACITY)) else $error("store over capacity");
  ap_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r && !out_ready |=> ovalid_r && $stable(med_r))
    else $error("result dropped");
endmodule

// ===== rtl/core/running_median_two_heaps_top.sv =====
// Top level of the two-heap running median block.
//
//  channel  | direction | payload
//  ---------+-----------+-------------------------------------------------
//  in_ch    | sink      | sample (SAMPLE_WIDTH bits, signed)
//  out_ch   | source    | median_doubled (33), stored_count (11), rejected_full (1)
//
// One item is handled at a time. For a stored item the heap tops are read before and
// after the update, a root replacement reads the left child, reads the right child and
// compares at each heap level, and a push reads the parent and compares at each level,
// since the sift loop goes through the single port of each heap RAM. A rejected item
// skips the heap operations and goes straight to the result. Reset is synchronous and
// active low and empties both heaps at once by clearing their sizes. The result sits
// in an output register; the next item is taken once that result has left.
module running_median_two_heaps_top #(
  parameter int unsigned CAPACITY     = 1024,
  parameter int unsigned SAMPLE_WIDTH = 32
) (
  input logic clk,
  input logic rst_n,
  rmth_if.sink   in_ch,
  rmth_if.source out_ch
);
  import rmth_pkg::*;

  // Each heap holds half of the store, rounded up.
  localparam int unsigned DEPTH = (CAPACITY + 1) / 2;

  rmth_cmd_t                  cmd;
  rmth_sts_t                  sts;
  logic [SAMPLE_WIDTH-1:0]    val, top;
  logic [$clog2(DEPTH):0]     size;
  logic [MEDIAN_WIDTH-1:0]    med;
  logic [COUNT_WIDTH-1:0]     cnt;
  logic                       rej;

  // Output payload packs median, count and the reject flag, high to low.
  assign out_ch.data = {med, cnt, rej};

  rmth_ctrl #(.SW(SAMPLE_WIDTH), .CAPACITY(CAPACITY), .DEPTH(DEPTH)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_sample (in_ch.data[SAMPLE_WIDTH-1:0]),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_median(med),
    .out_count (cnt),
    .out_rej   (rej),
    .cmd       (cmd),
    .val       (val),
    .size      (size),
    .sts       (sts),
    .top       (top)
  );

  // Datapath owns both heap memories and the sift engine.
  rmth_datapath #(.SW(SAMPLE_WIDTH), .DEPTH(DEPTH)) u_dp (
    .clk  (clk),
    .rst_n(rst_n),
    .cmd  (cmd),
    .val  (val),
    .size (size),
    .sts  (sts),
    .top  (top)
  );

  ap_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |-> !out_ch.valid) else $error("accept with result pending");
  ap_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> cnt <= COUNT_WIDTH'(CAPACITY)) else $error("count over capacity");
  ap_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.ready |=> !out_ch.valid) else $error("result repeated");
endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the two-heap running median block.
module tb;
  import rmth_pkg::*;

  localparam int unsigned CAP      = 1024;
  localparam int unsigned HDEPTH   = (CAP + 1) / 2;
  localparam int unsigned OUT_W    = MEDIAN_WIDTH + COUNT_WIDTH + 1;
  localparam int unsigned LIMIT    = 600000;
  localparam int unsigned SETTLE   = 80;
  localparam bit          LOWER    = 1'b0;
  localparam bit          UPPER    = 1'b1;

  typedef struct {
    logic signed [MEDIAN_WIDTH-1:0] median;
    logic [COUNT_WIDTH-1:0]         count;
    logic                           rejected;
  } median_result_t;

  logic clk;
  logic rst_n;

  rmth_if #(.W(32))    in_ch (clk);
  rmth_if #(.W(OUT_W)) out_ch (clk);

  running_median_two_heaps_top #(.CAPACITY(CAP), .SAMPLE_WIDTH(32)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Clock with a period of 4 time units.
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Mirror of the block's state: index LOWER is the max-heap holding the
  // lower half, index UPPER the min-heap holding the upper half.
  logic signed [31:0] heap_mem [2][HDEPTH];
  int unsigned        heap_size [2];

  median_result_t     pending_medians[$];
  int unsigned        send_idle_pct;
  int unsigned        recv_idle_pct;
  int unsigned        hold_cycles;
  int unsigned        cycle_count;
  int unsigned        error_count;
  logic signed [31:0] last_sample;

  // The max-heap ranks larger values higher, the min-heap smaller ones.
  function automatic bit ranks_above(bit upper, logic signed [31:0] a, logic signed [31:0] b);
    return upper ? (a < b) : (a > b);
  endfunction

  task automatic heap_push(bit upper, logic signed [31:0] v);
    int unsigned pos;
    int unsigned parent;
    logic signed [31:0] t;
    if (heap_size[upper] >= HDEPTH) return;
    pos = heap_size[upper];
    heap_mem[upper][pos] = v;
    while (pos > 0) begin
      parent = (pos - 1) / 2;
      if (!ranks_above(upper, heap_mem[upper][pos], heap_mem[upper][parent])) break;
      t = heap_mem[upper][pos];
      heap_mem[upper][pos] = heap_mem[upper][parent];
      heap_mem[upper][parent] = t;
      pos = parent;
    end
    heap_size[upper]++;
  endtask

  // Replace the root and sift it down to restore heap order.
  task automatic heap_replace_root(bit upper, logic signed [31:0] v);
    int unsigned pos;
    int unsigned l;
    int unsigned r;
    int unsigned best;
    logic signed [31:0] t;
    if (heap_size[upper] == 0) return;
    heap_mem[upper][0] = v;
    pos = 0;
    forever begin
      l = 2 * pos + 1;
      r = l + 1;
      best = pos;
      if (l < heap_size[upper] && ranks_above(upper, heap_mem[upper][l], heap_mem[upper][best]))
        best = l;
      if (r < heap_size[upper] && ranks_above(upper, heap_mem[upper][r], heap_mem[upper][best]))
        best = r;
      if (best == pos) break;
      t = heap_mem[upper][pos];
      heap_mem[upper][pos] = heap_mem[upper][best];
      heap_mem[upper][best] = t;
      pos = best;
    end
  endtask

  function automatic logic signed [MEDIAN_WIDTH-1:0] widen(logic signed [31:0] v);
    return {v[31], v};
  endfunction

  // Insert one sample into the mirrored heaps and queue the median it yields.
  task automatic track_median(logic signed [31:0] v);
    median_result_t     res;
    logic signed [31:0] top;
    res.rejected = (heap_size[LOWER] + heap_size[UPPER]) >= CAP;
    if (!res.rejected) begin
      if (heap_size[LOWER] == 0 || heap_mem[LOWER][0] >= v) begin
        if (heap_size[LOWER] > heap_size[UPPER]) begin
          // The lower half is already the larger one, so its old top moves up.
          top = heap_mem[LOWER][0];
          heap_replace_root(LOWER, v);
          heap_push(UPPER, top);
        end else begin
          heap_push(LOWER, v);
        end
      end else if (heap_size[UPPER] > heap_size[LOWER]) begin
        if (v <= heap_mem[UPPER][0]) begin
          heap_push(LOWER, v);
        end else begin
          top = heap_mem[UPPER][0];
          heap_replace_root(UPPER, v);
          heap_push(LOWER, top);
        end
      end else begin
        heap_push(UPPER, v);
      end
    end
    if (heap_size[LOWER] > heap_size[UPPER])
      res.median = widen(heap_mem[LOWER][0]) + widen(heap_mem[LOWER][0]);
    else if (heap_size[UPPER] > heap_size[LOWER])
      res.median = widen(heap_mem[UPPER][0]) + widen(heap_mem[UPPER][0]);
    else if (heap_size[LOWER] == 0)
      res.median = '0;
    else
      res.median = widen(heap_mem[LOWER][0]) + widen(heap_mem[UPPER][0]);
    res.count = COUNT_WIDTH'(heap_size[LOWER] + heap_size[UPPER]);
    pending_medians.push_back(res);
  endtask

  // Offer one sample, holding valid high across back-to-back items, and wait
  // until the block takes it. Inputs change only on the falling edge.
  task automatic send_sample(logic signed [31:0] v);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(4)) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.data  <= v;
    do @(posedge clk); while (!in_ch.ready);
    track_median(v);
    last_sample = v;
  endtask

  // A mix of full-range values, a narrow band that forces ties, values near
  // both extremes and straight repeats.
  function automatic logic signed [31:0] pick_sample();
    int unsigned k;
    k = $urandom_range(99);
    if (k < 40) return $urandom;
    if (k < 70) return $signed($urandom_range(40)) - 20;
    if (k < 80) return 32'sh7FFF_FFFF - $signed($urandom_range(8));
    if (k < 90) return 32'sh8000_0000 + $signed($urandom_range(8));
    return last_sample;
  endfunction

  // Receiver: ready changes on the falling edge, stalled at random or held
  // off completely while the hold counter runs.
  always @(negedge clk) begin
    if (hold_cycles != 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Result checker: each accepted result is matched with the oldest expectation.
  always @(posedge clk) begin
    median_result_t                 want;
    logic signed [MEDIAN_WIDTH-1:0] got_median;
    logic [COUNT_WIDTH-1:0]         got_count;
    logic                           got_rejected;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      {got_median, got_count, got_rejected} = out_ch.data;
      if (pending_medians.size() == 0) begin
        $error("unexpected result: median_doubled %0d", got_median);
        error_count++;
      end else begin
        want = pending_medians.pop_front();
        if (got_median !== want.median) begin
          $error("median_doubled: expected %0d, got %0d", want.median, got_median);
          error_count++;
        end
        if (got_count !== want.count) begin
          $error("stored_count: expected %0d, got %0d", want.count, got_count);
          error_count++;
        end
        if (got_rejected !== want.rejected) begin
          $error("rejected_full: expected %0d, got %0d", want.rejected, got_rejected);
          error_count++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // Extremes of the sample range, zero and minus one.
  task automatic test_extremes();
    send_sample(32'sh8000_0000);
    send_sample(32'sh7FFF_FFFF);
    send_sample(32'sh0000_0000);
    send_sample(-32'sd1);
    send_sample(32'sh7FFF_FFFF);
    send_sample(32'sh7FFF_FFFE);
    send_sample(32'sh8000_0001);
    send_sample(32'sh8000_0000);
  endtask

  // Ties and ordered runs exercise both root replacements and the equal
  // sizes case where both tops are summed.
  task automatic test_rebalance();
    for (int i = 0; i < 4; i++) send_sample(32'sd5);
    for (int i = 0; i < 5; i++) send_sample(32'sd100 + i);
    for (int i = 0; i < 5; i++) send_sample(-32'sd100 - i);
    send_sample(32'sd3);
  endtask

  // Random samples under one idling pattern.
  task automatic test_random(int unsigned n, int unsigned s_idle, int unsigned r_idle);
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    for (int unsigned i = 0; i < n; i++) send_sample(pick_sample());
  endtask

  // Long receiver hold-off while items keep coming, so the block stalls.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_cycles   = 400;
    for (int i = 0; i < 20; i++) send_sample(pick_sample());
  endtask

  // Keep going past capacity so that full-store rejections are seen, with
  // idling only in the phase past capacity.
  task automatic test_overflow();
    while (heap_size[LOWER] + heap_size[UPPER] < CAP) test_random(20, 0, 0);
    test_random(60, 33, 84);
  endtask

  initial begin
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.data    = '0;
    out_ch.ready  = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_cycles   = 0;
    cycle_count   = 0;
    error_count   = 0;
    last_sample   = '0;
    heap_size[LOWER] = 0;
    heap_size[UPPER] = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_extremes();
    test_rebalance();
    test_random(400, 33, 84);
    test_random(400, 84, 33);
    test_backpressure();
    test_random(300, 0, 0);
    test_overflow();

    @(negedge clk);
    in_ch.valid <= 1'b0;
    recv_idle_pct = 0;
    wait (pending_medians.size() == 0);
    repeat (SETTLE) @(posedge clk);
    if (error_count == 0 && pending_medians.size() == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

endmodule
